>>> hdl/assert_macros.svh
// Assertion macros for the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication failed");

// next-cycle implication
`define BSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle implication failed");

`endif

>>> hdl/bsc_pkg.sv
// Package for the barometric compensation block: types, constants, helpers.
// No dependencies; used by the configuration interface, divider and top level.
`timescale 1ns / 1ps

package bsc_pkg;

	localparam int DW = 32;
	localparam int CNT_W = $clog2(DW);
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_PRESSURE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEMPERATURE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OSS = 2'd3;

	localparam logic [1:0] OSS_RESET = 2'd3;

	localparam logic FUNC_TEMP = 1'b0;
	localparam logic FUNC_PRES = 1'b1;
	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_DIV0 = 1'b1;

	localparam logic [DW-1:0] C_T_OFFSET = 32'd4000;
	localparam logic [DW-1:0] C_X3_BIAS = 32'd32768;
	localparam logic [DW-1:0] C_P_SCALE = 32'd50000;
	localparam logic [DW-1:0] C_P_C3 = 32'd3038;
	localparam logic [DW-1:0] C_P_C7 = 32'hFFFF_E343; // -7357
	localparam logic [DW-1:0] C_P_BIAS = 32'd3791;
	localparam logic [DW-1:0] C_SIGN = 32'h8000_0000;

	typedef enum logic [4:0] {
		S_IDLE,
		S_T_MUL,
		S_T_DIV,
		S_T_WAIT,
		S_P_B6,
		S_P_SQ_MUL,
		S_P_SQ,
		S_P_B2_MUL,
		S_P_X1A,
		S_P_AC2_MUL,
		S_P_SUM3,
		S_P_B3,
		S_P_AC3_MUL,
		S_P_X1B,
		S_P_B1_MUL,
		S_P_X3,
		S_P_AC4_MUL,
		S_P_B4,
		S_P_B7_MUL,
		S_P_DIV,
		S_P_WAIT,
		S_P_PSQ_MUL,
		S_P_C3_MUL,
		S_P_X1C,
		S_P_C7_MUL,
		S_P_SUM,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic start;
		logic [DW-1:0] dividend;
		logic [DW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [DW-1:0] quotient;
	} div_rsp_t;

	function automatic logic [DW-1:0] sx16(input logic [15:0] v);
		return {{(DW-16){v[15]}}, v};
	endfunction

	function automatic logic [DW-1:0] asr(input logic [DW-1:0] v, input int unsigned n);
		return $unsigned($signed(v) >>> n);
	endfunction

endpackage

>>> hdl/bsc_in_if.sv
// Input channel: one raw reading per item.
// Depends on nothing.
`timescale 1ns / 1ps

interface bsc_in_if;
	logic valid;
	logic ready;
	logic func;
	logic [23:0] raw_reading;

	modport source(output valid, func, raw_reading, input ready);
	modport sink(input valid, func, raw_reading, output ready);
endinterface

>>> hdl/bsc_out_if.sv
// Output channel: one compensated result per item.
// Depends on nothing.
`timescale 1ns / 1ps

interface bsc_out_if;
	logic valid;
	logic ready;
	logic kind;
	logic [31:0] value;
	logic status;

	modport source(output valid, kind, value, status, input ready);
	modport sink(input valid, kind, value, status, output ready);
endinterface

>>> hdl/bsc_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on bsc_pkg for the index width.
`timescale 1ns / 1ps

interface bsc_cfg_if;
	logic valid;
	logic ready;
	logic [bsc_pkg::CFG_IDX_W-1:0] index;
	logic [63:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

>>> hdl/bsc_divider.sv
// Bit-serial unsigned divider, one quotient bit per cycle.
// Depends on bsc_pkg for the request and response structs.
`timescale 1ns / 1ps

module bsc_divider (
	input  logic clk,
	input  logic arst_n,
	input  bsc_pkg::div_req_t req,
	output bsc_pkg::div_rsp_t rsp
);

	logic [bsc_pkg::DW-1:0] rem_q;
	logic [bsc_pkg::DW-1:0] quo_q;
	logic [bsc_pkg::DW-1:0] dsr_q;
	logic [bsc_pkg::CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [bsc_pkg::DW:0] shifted;
	logic [bsc_pkg::DW:0] trial;

	assign shifted = {rem_q, quo_q[bsc_pkg::DW-1]};
	assign trial = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == bsc_pkg::CNT_W'(bsc_pkg::DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[bsc_pkg::DW]) begin
				rem_q <= trial[bsc_pkg::DW-1:0];
				quo_q <= {quo_q[bsc_pkg::DW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[bsc_pkg::DW-1:0];
				quo_q <= {quo_q[bsc_pkg::DW-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;

endmodule

>>> hdl/barometric_sensor_compensation.sv
// Barometric compensation top level: sequencer, shared multiplier, registers.
// Depends on bsc_pkg, the three channel interfaces and bsc_divider.
`timescale 1ns / 1ps

// One item at a time. A small sequencer drives one shared 32x32 multiplier
// (low word kept, registered), an adder/shifter and a bit-serial divider;
// a zero divisor ends the item early. The input is ready only while the
// sequencer is idle, which it enters in the same cycle as the result is
// presented. The result waits in an output register, so the next item can
// be taken while it is not yet collected. Configuration writes are always
// taken and must be made while no item is in flight. A temperature item
// with a nonzero divisor updates the kept compensation term used by later
// pressure items.
module barometric_sensor_compensation (
	input  logic clk,
	input  logic arst_n,
	bsc_in_if.sink reading,
	bsc_out_if.source result,
	bsc_cfg_if.sink cfg
);

	bsc_pkg::state_t state_q, state_d;

	logic [63:0] pcoef_q;
	logic [63:0] tcoef_q;
	logic [31:0] scoef_q;
	logic [1:0] oss_q;
	logic [31:0] term_q;

	logic func_q;
	logic [23:0] raw_q;
	logic [31:0] m_q, b6_q, sq_q, x_q, acc_q, b3_q, b4_q, p_q, val_q;
	logic sgn_q, post_q, st_q;

	logic ovalid_q, okind_q, ostatus_q;
	logic [31:0] ovalue_q;

	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, mc, md, b1, b2;
	logic [31:0] ut, up, scale;
	logic [31:0] x1_t, tdiv, tdend, x2_t, b5, b4_c;
	logic na, nb;
	logic [31:0] mul_a, mul_b, mul_p;
	logic mul_en;
	logic accept, emit;

	bsc_pkg::div_req_t div_req;
	bsc_pkg::div_rsp_t div_rsp;

	bsc_divider u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	assign ac1 = bsc_pkg::sx16(pcoef_q[63:48]);
	assign ac2 = bsc_pkg::sx16(pcoef_q[47:32]);
	assign ac3 = bsc_pkg::sx16(pcoef_q[31:16]);
	assign ac4 = {16'b0, pcoef_q[15:0]};
	assign ac5 = {16'b0, tcoef_q[63:48]};
	assign ac6 = {16'b0, tcoef_q[47:32]};
	assign mc = bsc_pkg::sx16(tcoef_q[31:16]);
	assign md = bsc_pkg::sx16(tcoef_q[15:0]);
	assign b1 = bsc_pkg::sx16(scoef_q[31:16]);
	assign b2 = bsc_pkg::sx16(scoef_q[15:0]);

	assign ut = {16'b0, raw_q[15:0]};
	assign up = {8'b0, raw_q} >> (4'd8 - {2'b0, oss_q});
	assign scale = bsc_pkg::C_P_SCALE >> oss_q;

	assign x1_t = bsc_pkg::asr(m_q, 15);
	assign tdiv = x1_t + md;
	assign tdend = mc << 11;
	assign na = tdend[31];
	assign nb = tdiv[31];
	assign x2_t = sgn_q ? (32'd0 - div_rsp.quotient) : div_rsp.quotient;
	assign b5 = x_q + x2_t;
	assign b4_c = m_q >> 15;

	assign mul_p = mul_a * mul_b;

	assign accept = reading.valid && reading.ready;
	assign emit = (state_q == bsc_pkg::S_EMIT) && (!ovalid_q || result.ready);

	assign reading.ready = (state_q == bsc_pkg::S_IDLE);
	assign cfg.ready = 1'b1;
	assign result.valid = ovalid_q;
	assign result.kind = okind_q;
	assign result.value = ovalue_q;
	assign result.status = ostatus_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mul_en = 1'b0;
		mul_a = m_q;
		mul_b = b6_q;
		div_req.start = 1'b0;
		div_req.dividend = m_q;
		div_req.divisor = b4_q;
		case (state_q)
			bsc_pkg::S_IDLE: begin
				if (reading.valid) begin
					state_d = (reading.func == bsc_pkg::FUNC_PRES) ?
						bsc_pkg::S_P_B6 : bsc_pkg::S_T_MUL;
				end
			end
			bsc_pkg::S_T_MUL: begin
				mul_en = 1'b1;
				mul_a = ut - ac6;
				mul_b = ac5;
				state_d = bsc_pkg::S_T_DIV;
			end
			bsc_pkg::S_T_DIV: begin
				div_req.dividend = na ? (32'd0 - tdend) : tdend;
				div_req.divisor = nb ? (32'd0 - tdiv) : tdiv;
				if (tdiv == 32'd0) begin
					state_d = bsc_pkg::S_EMIT;
				end else begin
					div_req.start = 1'b1;
					state_d = bsc_pkg::S_T_WAIT;
				end
			end
			bsc_pkg::S_T_WAIT: begin
				if (div_rsp.done) state_d = bsc_pkg::S_EMIT;
			end
			bsc_pkg::S_P_B6: state_d = bsc_pkg::S_P_SQ_MUL;
			bsc_pkg::S_P_SQ_MUL: begin
				mul_en = 1'b1;
				mul_a = b6_q;
				mul_b = b6_q;
				state_d = bsc_pkg::S_P_SQ;
			end
			bsc_pkg::S_P_SQ: state_d = bsc_pkg::S_P_B2_MUL;
			bsc_pkg::S_P_B2_MUL: begin
				mul_en = 1'b1;
				mul_a = b2;
				mul_b = sq_q;
				state_d = bsc_pkg::S_P_X1A;
			end
			bsc_pkg::S_P_X1A: state_d = bsc_pkg::S_P_AC2_MUL;
			bsc_pkg::S_P_AC2_MUL: begin
				mul_en = 1'b1;
				mul_a = ac2;
				mul_b = b6_q;
				state_d = bsc_pkg::S_P_SUM3;
			end
			bsc_pkg::S_P_SUM3: state_d = bsc_pkg::S_P_B3;
			bsc_pkg::S_P_B3: state_d = bsc_pkg::S_P_AC3_MUL;
			bsc_pkg::S_P_AC3_MUL: begin
				mul_en = 1'b1;
				mul_a = ac3;
				mul_b = b6_q;
				state_d = bsc_pkg::S_P_X1B;
			end
			bsc_pkg::S_P_X1B: state_d = bsc_pkg::S_P_B1_MUL;
			bsc_pkg::S_P_B1_MUL: begin
				mul_en = 1'b1;
				mul_a = b1;
				mul_b = sq_q;
				state_d = bsc_pkg::S_P_X3;
			end
			bsc_pkg::S_P_X3: state_d = bsc_pkg::S_P_AC4_MUL;
			bsc_pkg::S_P_AC4_MUL: begin
				mul_en = 1'b1;
				mul_a = ac4;
				mul_b = acc_q + bsc_pkg::C_X3_BIAS;
				state_d = bsc_pkg::S_P_B4;
			end
			bsc_pkg::S_P_B4: begin
				state_d = (b4_c == 32'd0) ? bsc_pkg::S_EMIT : bsc_pkg::S_P_B7_MUL;
			end
			bsc_pkg::S_P_B7_MUL: begin
				mul_en = 1'b1;
				mul_a = up - b3_q;
				mul_b = scale;
				state_d = bsc_pkg::S_P_DIV;
			end
			bsc_pkg::S_P_DIV: begin
				div_req.start = 1'b1;
				div_req.dividend = (m_q < bsc_pkg::C_SIGN) ? (m_q << 1) : m_q;
				div_req.divisor = b4_q;
				state_d = bsc_pkg::S_P_WAIT;
			end
			bsc_pkg::S_P_WAIT: begin
				if (div_rsp.done) state_d = bsc_pkg::S_P_PSQ_MUL;
			end
			bsc_pkg::S_P_PSQ_MUL: begin
				mul_en = 1'b1;
				mul_a = bsc_pkg::asr(p_q, 8);
				mul_b = bsc_pkg::asr(p_q, 8);
				state_d = bsc_pkg::S_P_C3_MUL;
			end
			bsc_pkg::S_P_C3_MUL: begin
				mul_en = 1'b1;
				mul_a = m_q;
				mul_b = bsc_pkg::C_P_C3;
				state_d = bsc_pkg::S_P_X1C;
			end
			bsc_pkg::S_P_X1C: state_d = bsc_pkg::S_P_C7_MUL;
			bsc_pkg::S_P_C7_MUL: begin
				mul_en = 1'b1;
				mul_a = bsc_pkg::C_P_C7;
				mul_b = p_q;
				state_d = bsc_pkg::S_P_SUM;
			end
			bsc_pkg::S_P_SUM: state_d = bsc_pkg::S_EMIT;
			bsc_pkg::S_EMIT: begin
				if (!ovalid_q || result.ready) state_d = bsc_pkg::S_IDLE;
			end
			default: state_d = bsc_pkg::S_IDLE;
		endcase
	end

	// datapath working registers
	always_ff @(posedge clk) begin
		if (mul_en) m_q <= mul_p;
		case (state_q)
			bsc_pkg::S_IDLE: begin
				if (accept) begin
					func_q <= reading.func;
					raw_q <= reading.raw_reading;
				end
			end
			bsc_pkg::S_T_DIV: begin
				x_q <= x1_t;
				sgn_q <= na ^ nb;
				val_q <= '0;
				st_q <= (tdiv == 32'd0) ? bsc_pkg::STATUS_DIV0 : bsc_pkg::STATUS_OK;
			end
			bsc_pkg::S_T_WAIT: begin
				if (div_rsp.done) val_q <= bsc_pkg::asr(b5 + 32'd8, 4);
			end
			bsc_pkg::S_P_B6: b6_q <= term_q - bsc_pkg::C_T_OFFSET;
			bsc_pkg::S_P_SQ: sq_q <= bsc_pkg::asr(m_q, 12);
			bsc_pkg::S_P_X1A: x_q <= bsc_pkg::asr(m_q, 11);
			bsc_pkg::S_P_SUM3: acc_q <= (ac1 << 2) + x_q + bsc_pkg::asr(m_q, 11);
			bsc_pkg::S_P_B3: b3_q <= bsc_pkg::asr((acc_q << oss_q) + 32'd2, 2);
			bsc_pkg::S_P_X1B: x_q <= bsc_pkg::asr(m_q, 13);
			bsc_pkg::S_P_X3: acc_q <= bsc_pkg::asr(x_q + bsc_pkg::asr(m_q, 16) + 32'd2, 2);
			bsc_pkg::S_P_B4: begin
				b4_q <= b4_c;
				val_q <= '0;
				st_q <= (b4_c == 32'd0) ? bsc_pkg::STATUS_DIV0 : bsc_pkg::STATUS_OK;
			end
			bsc_pkg::S_P_DIV: post_q <= m_q[31];
			bsc_pkg::S_P_WAIT: begin
				if (div_rsp.done) begin
					p_q <= post_q ? (div_rsp.quotient << 1) : div_rsp.quotient;
				end
			end
			bsc_pkg::S_P_X1C: x_q <= bsc_pkg::asr(m_q, 16);
			bsc_pkg::S_P_SUM: begin
				val_q <= p_q + bsc_pkg::asr(x_q + bsc_pkg::asr(m_q, 16) + bsc_pkg::C_P_BIAS, 4);
			end
			default: ;
		endcase
	end

	// configuration and kept compensation term
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcoef_q <= '0;
			tcoef_q <= '0;
			scoef_q <= '0;
			oss_q <= bsc_pkg::OSS_RESET;
			term_q <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					bsc_pkg::REG_PRESSURE: pcoef_q <= cfg.data;
					bsc_pkg::REG_TEMPERATURE: tcoef_q <= cfg.data;
					bsc_pkg::REG_SECOND: scoef_q <= cfg.data[31:0];
					bsc_pkg::REG_OSS: oss_q <= cfg.data[1:0];
					default: ;
				endcase
			end
			if (state_q == bsc_pkg::S_T_WAIT && div_rsp.done) term_q <= b5;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (emit) begin
			ovalid_q <= 1'b1;
		end else if (result.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			okind_q <= func_q;
			ovalue_q <= val_q;
			ostatus_q <= st_q;
		end
	end

endmodule

>>> hdl/bsc_checker.sv
// Port-level checker for the barometric compensation top level, with bind.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bsc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_kind,
	input logic [31:0] out_value,
	input logic out_status
);

	`BSC_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	`BSC_ASSERT_IMP(a_fault_gives_zero, clk, arst_n, out_valid && out_status, out_value == 32'd0)
	`BSC_ASSERT_IMP(a_result_frees_input, clk, arst_n, $rose(out_valid), in_ready)
	`BSC_ASSERT_NEXT(a_stalled_result_holds, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_kind) && $stable(out_status))

endmodule

bind barometric_sensor_compensation bsc_checker u_bsc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (reading.valid),
	.in_ready  (reading.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_kind  (result.kind),
	.out_value (result.value),
	.out_status(result.status)
);
